### rtl/core/kvt_pkg.sv
package kvt_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int ENTRY_W = KEY_W + VAL_W;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 7;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic signed [VAL_W-1:0] NULL_RESET = -32'sd111111;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    // register index carried by paddr[2]
    typedef enum logic {
        REG_NULL_VALUE = 1'b0
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

    // memory port controls from the sequencer
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctrl_t;

endpackage

### rtl/core/kvt_cfg.sv
module kvt_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kvt_pkg::ADDR_W-1:0]          paddr,
    input  logic [kvt_pkg::DATA_W-1:0]          pwdata,
    output logic [kvt_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    output logic signed [kvt_pkg::VAL_W-1:0]    null_value
);
    import kvt_pkg::*;

    logic signed [VAL_W-1:0] null_value_reg;
    logic signed [VAL_W-1:0] null_value_next;
    logic                    wr_en;
    reg_idx_t                reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        null_value_next = null_value_reg;
        if (wr_en && (reg_idx == REG_NULL_VALUE))
        begin
            null_value_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            null_value_reg <= NULL_RESET;
        end
        else
        begin
            null_value_reg <= null_value_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_NULL_VALUE: prdata = null_value_reg;
            default:        prdata = '0;
        endcase
    end

    assign null_value = null_value_reg;

endmodule

### rtl/core/kvt_store.sv
module kvt_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                         clk,
    input  kvt_pkg::mem_ctrl_t           ctrl,
    input  logic [AW-1:0]                waddr,
    input  logic [kvt_pkg::ENTRY_W-1:0]  wdata,
    input  logic [AW-1:0]                raddr,
    output logic [kvt_pkg::ENTRY_W-1:0]  rdata
);
    import kvt_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctrl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/kvt_seq.sv
module kvt_seq #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [kvt_pkg::CMD_W-1:0]           cmd,
    input  logic signed [kvt_pkg::KEY_W-1:0]    key,
    input  logic signed [kvt_pkg::VAL_W-1:0]    value_in,
    input  logic signed [kvt_pkg::VAL_W-1:0]    null_value,
    output logic                                done,
    output logic                                hit,
    output logic signed [kvt_pkg::VAL_W-1:0]    value_out,
    output logic                                status,
    output logic [CW-1:0]                       entry_count,
    output kvt_pkg::mem_ctrl_t                  mem_ctrl,
    output logic [AW-1:0]                       mem_waddr,
    output logic [kvt_pkg::ENTRY_W-1:0]         mem_wdata,
    output logic [AW-1:0]                       mem_raddr,
    input  logic [kvt_pkg::ENTRY_W-1:0]         mem_rdata
);
    import kvt_pkg::*;

    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    state_t                  state_reg, state_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [VAL_W-1:0]        val_reg, val_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    hit_reg, hit_next;
    logic [VAL_W-1:0]        vout_reg, vout_next;
    logic                    status_reg, status_next;

    logic                    at_end;
    logic                    full;
    logic                    key_match;
    logic                    shift_more;
    logic                    cmd_ok;
    logic [CW-1:0]           idx_inc;

    // the one comparator, reused each scan step
    assign key_match  = (mem_rdata[ENTRY_W-1:VAL_W] == key_reg);
    assign idx_inc    = idx_reg + 1'b1;
    assign at_end     = (idx_reg == count_reg);
    assign full       = (count_reg == CAP);
    assign shift_more = (idx_inc < count_reg);
    assign cmd_ok     = (cmd == CMD_INSERT) || (cmd == CMD_LOOKUP) || (cmd == CMD_REMOVE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cmd_ok ? ST_SCAN_RD : ST_DONE;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = at_end ? ST_DONE : ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (key_match)
                begin
                    state_next = (cmd_reg == CMD_REMOVE) ? ST_SHIFT_RD : ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                state_next = shift_more ? ST_SHIFT_WR : ST_DONE;
            end
            ST_SHIFT_WR:
            begin
                state_next = ST_SHIFT_RD;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        hit_next    = hit_reg;
        vout_next   = vout_reg;
        status_next = status_reg;
        mem_ctrl    = '0;
        mem_waddr   = idx_reg[AW-1:0];
        mem_wdata   = {key_reg, val_reg};
        mem_raddr   = idx_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    key_next    = key;
                    val_next    = value_in;
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    status_next = 1'b0;
                    vout_next   = null_value;
                end
            end
            ST_SCAN_RD:
            begin
                if (at_end)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            mem_ctrl.we = 1'b1;
                            mem_waddr   = count_reg[AW-1:0];
                            count_next  = count_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    mem_ctrl.re = 1'b1;
                end
            end
            ST_SCAN_CMP:
            begin
                if (key_match)
                begin
                    hit_next  = 1'b1;
                    vout_next = mem_rdata[VAL_W-1:0];
                    if (cmd_reg == CMD_INSERT)
                    begin
                        mem_ctrl.we = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_SHIFT_RD:
            begin
                if (shift_more)
                begin
                    mem_ctrl.re = 1'b1;
                    mem_raddr   = idx_inc[AW-1:0];
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            ST_SHIFT_WR:
            begin
                // move the later entry down one slot
                mem_ctrl.we = 1'b1;
                mem_wdata   = mem_rdata;
                idx_next    = idx_inc;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        vout_reg   <= vout_next;
        status_reg <= status_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = (state_reg == ST_DONE);
    assign hit         = hit_reg;
    assign value_out   = vout_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("entry count above capacity");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> !hit)
        else $error("full status with hit");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_CMP) |-> (idx_reg < count_reg))
        else $error("compare beyond valid entries");

    a_count_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == ST_DONE))
        else $error("entry count changed mid transaction");
`endif

endmodule

### rtl/core/key_value_table.sv
// Key-value table holding up to CAPACITY entries in insertion order in a
// single-port-read memory, searched by one comparator under a small
// sequencer. A transaction is taken when start is high and busy is low;
// busy then stays high until the result has been shown. Each memory entry
// is read and then compared in turn until the key matches or the entries
// run out; a remove then moves every later entry down one slot. An unused
// command goes straight to the result. The result is presented for exactly
// one cycle with done high and cannot be held off. null_value may only be
// written while busy is low.
module key_value_table #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [kvt_pkg::CMD_W-1:0]           cmd,
    input  logic signed [kvt_pkg::KEY_W-1:0]    key,
    input  logic signed [kvt_pkg::VAL_W-1:0]    value_in,
    output logic                                done,
    output logic                                hit,
    output logic signed [kvt_pkg::VAL_W-1:0]    value_out,
    output logic                                status,
    output logic [kvt_pkg::COUNT_W-1:0]         count,
    output logic                                empty_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kvt_pkg::ADDR_W-1:0]          paddr,
    input  logic [kvt_pkg::DATA_W-1:0]          pwdata,
    output logic [kvt_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import kvt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VAL_W-1:0] null_value;
    mem_ctrl_t               mem_ctrl;
    logic [AW-1:0]           mem_waddr;
    logic [AW-1:0]           mem_raddr;
    logic [ENTRY_W-1:0]      mem_wdata;
    logic [ENTRY_W-1:0]      mem_rdata;
    logic [CW-1:0]           entry_count;
    logic [CW+COUNT_W-1:0]   count_ext;

    kvt_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .null_value (null_value)
    );

    kvt_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    kvt_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .key         (key),
        .value_in    (value_in),
        .null_value  (null_value),
        .done        (done),
        .hit         (hit),
        .value_out   (value_out),
        .status      (status),
        .entry_count (entry_count),
        .mem_ctrl    (mem_ctrl),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // count port carries the low bits of the entry count
    assign count_ext = {{COUNT_W{1'b0}}, entry_count};
    assign count     = count_ext[COUNT_W-1:0];
    assign empty_res = (entry_count == '0);

endmodule
